// ===== rtl/ekps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekps_pkg: shared types and constants of the expiring keyed position store
// Holds the store geometry, the operation and status codes and the entry
// record that moves from cell to cell along the ring.
// ----------------------------------------------------------------------------
package ekps_pkg;

  localparam int ENTRIES   = 256;
  localparam int KEY_CHARS = 9;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = 9;

  localparam logic [19:0] STORE_TIME_RST = 20'd3600;
  localparam logic [11:0] MARGIN_RST     = 12'd300;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_KILL    = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_CLEANUP = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_ADDED       = 3'd0,
    ST_UPDATED     = 3'd1,
    ST_REMOVED     = 3'd2,
    ST_KILL_ABSENT = 3'd3,
    ST_FOUND       = 3'd4,
    ST_NOT_FOUND   = 3'd5,
    ST_FULL        = 3'd6,
    ST_NO_POSITION = 3'd7
  } status_e;

  typedef enum logic {
    REG_STORE_TIME = 1'b0,
    REG_MARGIN     = 1'b1
  } reg_e;

  // One stored entry.
  typedef struct packed {
    logic        valid;
    logic [63:0] key_head;
    logic [7:0]  key_last;
    logic [3:0]  key_len;
    logic [31:0] time_s;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [31:0] coslat;
    logic [15:0] kind;
    logic [31:0] flags;
  } entry_t;

endpackage

// ===== rtl/ekps_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekps_cell: one slot of the store ring
// Holds one entry and takes its neighbor's entry whenever the ring shifts.
// ----------------------------------------------------------------------------
module ekps_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  ekps_pkg::entry_t  entry_i,
  output ekps_pkg::entry_t  entry_o
);

  logic             valid_q;
  ekps_pkg::entry_t data_q;

  // The valid bit is cleared at reset; the record itself needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= entry_i;
    end
  end

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

endmodule

// ===== rtl/ekps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekps_ctrl: sequencer and head unit of the store ring
// Takes transactions, rotates the ring once per pass and edits the entry at
// the head of the ring: purge, match, update, kill, lookup and fill.
// ----------------------------------------------------------------------------
module ekps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [19:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [63:0]       key_low_i,
  input  logic [7:0]        key_tail_i,
  input  logic [3:0]        key_length_i,
  input  logic [31:0]       current_time_i,
  input  logic [31:0]       arrival_time_i,
  input  logic              has_position_i,
  input  logic [31:0]       latitude_bits_i,
  input  logic [31:0]       longitude_bits_i,
  input  logic [31:0]       cos_latitude_bits_i,
  input  logic [15:0]       packet_kind_i,
  input  logic [31:0]       packet_flags_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [31:0]       found_latitude_o,
  output logic [31:0]       found_longitude_o,
  output logic [31:0]       found_cos_latitude_o,
  output logic [31:0]       found_time_o,
  output logic [15:0]       found_kind_o,
  output logic [31:0]       found_flags_o,
  output logic [8:0]        purged_count_o,
  output logic              shift_o,
  input  ekps_pkg::entry_t  head_i,
  output ekps_pkg::entry_t  head_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_DONE
  } state_e;

  state_e                          state_q;
  logic [ekps_pkg::IDX_W-1:0]      cnt_q;
  logic [19:0]                     store_time_q;
  logic [11:0]                     margin_q;
  ekps_pkg::op_e                   op_q;
  ekps_pkg::entry_t                item_q;
  logic [32:0]                     now_q;
  logic [32:0]                     now_m_q;
  logic                            hit_q;
  logic                            filled_q;
  ekps_pkg::status_e               status_q;
  logic [ekps_pkg::CNT_W-1:0]      purged_q;
  ekps_pkg::entry_t                cap_q;
  logic                            out_valid_q;
  ekps_pkg::status_e               out_status_q;
  ekps_pkg::entry_t                out_rec_q;
  logic [ekps_pkg::CNT_W-1:0]      out_purged_q;

  logic [3:0]        len_sat;
  logic [63:0]       head_norm;
  logic [7:0]        last_norm;
  logic              in_accept;
  logic              last_cell;
  logic [32:0]       expire_at;
  logic              expired;
  logic              match;
  logic              fresh;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign shift_o = (state_q == S_SCAN) || (state_q == S_FILL);
  assign last_cell = (cnt_q == ekps_pkg::IDX_W'(ekps_pkg::ENTRIES - 1));

  // Key normalization: saturate the length and zero the unused characters.
  always_comb begin
    len_sat = (key_length_i > 4'(ekps_pkg::KEY_CHARS)) ?
              4'(ekps_pkg::KEY_CHARS) : key_length_i;
    for (int k = 0; k < 8; k++) begin
      head_norm[8*k +: 8] = (4'(k) < len_sat) ? key_low_i[8*k +: 8] : 8'd0;
    end
    last_norm = (len_sat > 4'd8) ? key_tail_i : 8'd0;
  end

  // Per-entry checks at the head of the ring.
  always_comb begin
    expire_at = {1'b0, head_i.time_s} + {13'd0, store_time_q};
    expired   = head_i.valid && (expire_at < now_q);
    match     = head_i.valid && !expired &&
                (head_i.key_len == item_q.key_len) &&
                (head_i.key_head == item_q.key_head) &&
                (head_i.key_last == item_q.key_last);
    fresh     = expire_at > now_m_q;
  end

  // Edit of the head entry on its way to the tail of the ring.
  always_comb begin
    head_o = head_i;
    if (state_q == S_SCAN) begin
      if (expired) begin
        head_o.valid = 1'b0;
      end
      if (match && (op_q == ekps_pkg::OP_INSERT)) begin
        head_o.time_s = item_q.time_s;
        head_o.lat    = item_q.lat;
        head_o.lon    = item_q.lon;
        head_o.coslat = item_q.coslat;
        head_o.kind   = item_q.kind;
        head_o.flags  = item_q.flags;
      end
      if (match && (op_q == ekps_pkg::OP_KILL)) begin
        head_o.valid = 1'b0;
      end
    end else if (state_q == S_FILL) begin
      if (!head_i.valid && !filled_q) begin
        head_o       = item_q;
        head_o.valid = 1'b1;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_time_q <= ekps_pkg::STORE_TIME_RST;
      margin_q     <= ekps_pkg::MARGIN_RST;
    end else if (cfg_we_i) begin
      case (ekps_pkg::reg_e'(cfg_index_i))
        ekps_pkg::REG_STORE_TIME: store_time_q <= cfg_data_i;
        ekps_pkg::REG_MARGIN:     margin_q     <= cfg_data_i[11:0];
        default:                  margin_q     <= margin_q;
      endcase
    end
  end

  // Item registers, captured at acceptance and during the scan.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q            <= ekps_pkg::op_e'(operation_i);
      item_q.valid    <= 1'b1;
      item_q.key_head <= head_norm;
      item_q.key_last <= last_norm;
      item_q.key_len  <= len_sat;
      item_q.time_s   <= arrival_time_i;
      item_q.lat      <= latitude_bits_i;
      item_q.lon      <= longitude_bits_i;
      item_q.coslat   <= cos_latitude_bits_i;
      item_q.kind     <= packet_kind_i;
      item_q.flags    <= packet_flags_i;
      now_q           <= {1'b0, current_time_i};
      now_m_q         <= {1'b0, current_time_i} + {21'd0, margin_q};
      cap_q           <= '0;
    end else if ((state_q == S_SCAN) && match && (op_q == ekps_pkg::OP_LOOKUP) &&
                 fresh && !hit_q) begin
      cap_q <= head_i;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      hit_q        <= 1'b0;
      filled_q     <= 1'b0;
      status_q     <= ekps_pkg::ST_ADDED;
      purged_q     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ekps_pkg::ST_ADDED;
      out_rec_q    <= '0;
      out_purged_q <= '0;
    end else begin
      // The done state loads the result register itself.
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            cnt_q    <= '0;
            hit_q    <= 1'b0;
            filled_q <= 1'b0;
            purged_q <= '0;
            if ((ekps_pkg::op_e'(operation_i) == ekps_pkg::OP_INSERT) &&
                !has_position_i) begin
              status_q <= ekps_pkg::ST_NO_POSITION;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (expired) begin
            purged_q <= purged_q + 1'b1;
          end
          if (match && ((op_q != ekps_pkg::OP_LOOKUP) || fresh)) begin
            hit_q <= 1'b1;
          end
          cnt_q <= last_cell ? '0 : cnt_q + 1'b1;
          if (last_cell) begin
            case (op_q)
              ekps_pkg::OP_INSERT: begin
                status_q <= ekps_pkg::ST_UPDATED;
                state_q  <= (hit_q || match) ? S_DONE : S_FILL;
              end
              ekps_pkg::OP_KILL: begin
                status_q <= (hit_q || match) ? ekps_pkg::ST_REMOVED :
                            ekps_pkg::ST_KILL_ABSENT;
                state_q  <= S_DONE;
              end
              ekps_pkg::OP_LOOKUP: begin
                status_q <= (hit_q || (match && fresh)) ? ekps_pkg::ST_FOUND :
                            ekps_pkg::ST_NOT_FOUND;
                state_q  <= S_DONE;
              end
              default: begin
                status_q <= ekps_pkg::ST_ADDED;
                state_q  <= S_DONE;
              end
            endcase
          end
        end
        S_FILL: begin
          if (!head_i.valid) begin
            filled_q <= 1'b1;
          end
          cnt_q <= last_cell ? '0 : cnt_q + 1'b1;
          if (last_cell) begin
            status_q <= (filled_q || !head_i.valid) ? ekps_pkg::ST_ADDED :
                        ekps_pkg::ST_FULL;
            state_q  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_rec_q    <= (status_q == ekps_pkg::ST_FOUND) ? cap_q : '0;
            out_purged_q <= purged_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_status_q;
  assign found_latitude_o     = out_rec_q.lat;
  assign found_longitude_o    = out_rec_q.lon;
  assign found_cos_latitude_o = out_rec_q.coslat;
  assign found_time_o         = out_rec_q.time_s;
  assign found_kind_o         = out_rec_q.kind;
  assign found_flags_o        = out_rec_q.flags;
  assign purged_count_o       = out_purged_q;

endmodule

// ===== rtl/expiring_keyed_position_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expiring_keyed_position_store: keyed store of last known positions
// Entries expire after a programmable store time; lookups stop returning an
// entry a programmable margin before it expires.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions carry an operation (insert, kill, lookup, cleanup),
//   a key of up to nine characters, the present time and an insert record.
//   Each input transaction yields exactly one output transaction.
//   The entries sit in a ring of cells that rotates one place per cycle
//   while a transaction is scanning; a single head unit edits the entry
//   passing it. One full rotation through all ENTRIES cells is one pass.
//   An insert without position makes no pass; other operations make one,
//   and an insert that adds a new key takes a second pass to place it in
//   the lowest free slot.
//   One transaction is in work at a time; in_stall_o is high while busy.
//   A finished result waits in the output register while out_stall_i is
//   high, and the next input transaction may be taken meanwhile.
//   Reset clears all entries and loads the default store time and margin.
//   Configuration is to be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module expiring_keyed_position_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [19:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] key_low_i,
  input  logic [7:0]  key_tail_i,
  input  logic [3:0]  key_length_i,
  input  logic [31:0] current_time_i,
  input  logic [31:0] arrival_time_i,
  input  logic        has_position_i,
  input  logic [31:0] latitude_bits_i,
  input  logic [31:0] longitude_bits_i,
  input  logic [31:0] cos_latitude_bits_i,
  input  logic [15:0] packet_kind_i,
  input  logic [31:0] packet_flags_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] found_latitude_o,
  output logic [31:0] found_longitude_o,
  output logic [31:0] found_cos_latitude_o,
  output logic [31:0] found_time_o,
  output logic [15:0] found_kind_o,
  output logic [31:0] found_flags_o,
  output logic [8:0]  purged_count_o
);

  ekps_pkg::entry_t ring [ekps_pkg::ENTRIES];
  ekps_pkg::entry_t head_new;
  logic             shift;

  // Sequencer and head unit.
  ekps_ctrl u_ctrl (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .operation_i          (operation_i),
    .key_low_i            (key_low_i),
    .key_tail_i           (key_tail_i),
    .key_length_i         (key_length_i),
    .current_time_i       (current_time_i),
    .arrival_time_i       (arrival_time_i),
    .has_position_i       (has_position_i),
    .latitude_bits_i      (latitude_bits_i),
    .longitude_bits_i     (longitude_bits_i),
    .cos_latitude_bits_i  (cos_latitude_bits_i),
    .packet_kind_i        (packet_kind_i),
    .packet_flags_i       (packet_flags_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .status_o             (status_o),
    .found_latitude_o     (found_latitude_o),
    .found_longitude_o    (found_longitude_o),
    .found_cos_latitude_o (found_cos_latitude_o),
    .found_time_o         (found_time_o),
    .found_kind_o         (found_kind_o),
    .found_flags_o        (found_flags_o),
    .purged_count_o       (purged_count_o),
    .shift_o              (shift),
    .head_i               (ring[0]),
    .head_o               (head_new)
  );

  // Ring of cells: each takes its upper neighbor, the last takes the edited head.
  for (genvar g = 0; g < ekps_pkg::ENTRIES; g++) begin : g_cell
    ekps_pkg::entry_t cell_in;
    if (g == ekps_pkg::ENTRIES - 1) begin : g_tail
      assign cell_in = head_new;
    end else begin : g_link
      assign cell_in = ring[g + 1];
    end
    ekps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (cell_in),
      .entry_o (ring[g])
    );
  end

endmodule

// ===== rtl/ekps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekps_checker: port-level checks of the expiring keyed position store
// Watches the top-level ports and flags results or handshakes out of line.
// ----------------------------------------------------------------------------
module ekps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [31:0] found_latitude_o,
  input logic [31:0] found_time_o,
  input logic [31:0] found_flags_o,
  input logic [8:0]  purged_count_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The block is busy right after taking a transaction.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

  // Record fields are zero unless the entry was found.
  a_zero_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ekps_pkg::ST_FOUND) |->
      (found_latitude_o == 32'd0) && (found_time_o == 32'd0) &&
      (found_flags_o == 32'd0))
    else $error("record data on a result without a find");

  // An insert without position does not scan, so nothing is purged.
  a_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ekps_pkg::ST_NO_POSITION) |->
      (purged_count_o == 9'd0))
    else $error("purge reported without a scan");

endmodule

bind expiring_keyed_position_store ekps_checker u_ekps_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .found_latitude_o (found_latitude_o),
  .found_time_o     (found_time_o),
  .found_flags_o    (found_flags_o),
  .purged_count_o   (purged_count_o)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the expiring keyed position store
// Drives insert, kill, lookup and cleanup transactions through the valid and
// stall handshake and keeps its own copy of the store. That copy predicts the
// status, the found record and the purge count of every result. Directed tests
// cover the corner cases and a completely full store. Random phases run under
// several store time and margin settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

  // One input transaction.
  typedef struct {
    ekps_pkg::op_e op;
    logic [63:0] key_low;
    logic [7:0]  key_tail;
    logic [3:0]  key_length;
    logic [31:0] now_s;
    logic [31:0] arrival_s;
    logic        has_pos;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [31:0] coslat;
    logic [15:0] kind;
    logic [31:0] flags;
  } query_t;

  // One output transaction.
  typedef struct {
    ekps_pkg::status_e status;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [31:0] coslat;
    logic [31:0] time_s;
    logic [15:0] kind;
    logic [31:0] flags;
    logic [8:0]  purged;
  } reply_t;

  localparam int POOL = 48;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [19:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  operation_i;
  logic [63:0] key_low_i;
  logic [7:0]  key_tail_i;
  logic [3:0]  key_length_i;
  logic [31:0] current_time_i;
  logic [31:0] arrival_time_i;
  logic        has_position_i;
  logic [31:0] latitude_bits_i;
  logic [31:0] longitude_bits_i;
  logic [31:0] cos_latitude_bits_i;
  logic [15:0] packet_kind_i;
  logic [31:0] packet_flags_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [31:0] found_latitude_o;
  logic [31:0] found_longitude_o;
  logic [31:0] found_cos_latitude_o;
  logic [31:0] found_time_o;
  logic [15:0] found_kind_o;
  logic [31:0] found_flags_o;
  logic [8:0]  purged_count_o;

  // Predicted store contents and configuration.
  ekps_pkg::entry_t slots [ekps_pkg::ENTRIES];
  logic [19:0] store_time_s;
  logic [11:0] margin_s;

  reply_t      pending_replies[$];
  int          errors;
  int          replies_seen;
  int          status_seen [8];
  int          purged_total;
  bit          quiet;
  logic [31:0] clock_s;
  logic [63:0] pool_key [POOL];
  logic [7:0]  pool_tail [POOL];
  logic [3:0]  pool_len [POOL];

  expiring_keyed_position_store i_dut (.*);

  always #10 clk_i = ~clk_i;

  initial begin
    #60_000_000;
    $display("expiring_keyed_position_store: mismatch");
    $finish;
  end

  // Expected outcome of one transaction; updates the predicted store.
  function automatic reply_t predict_store(input query_t q);
    reply_t      r;
    logic [3:0]  len;
    logic [63:0] mask;
    logic [63:0] head;
    logic [7:0]  last;
    int          freed;
    bit          hit;
    r = '{status: ekps_pkg::ST_ADDED, default: '0};
    len = (q.key_length > 4'd9) ? 4'd9 : q.key_length;
    mask = (len >= 4'd8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
    head = q.key_low & mask;
    last = (len == 4'd9) ? q.key_tail : 8'd0;
    if (q.op == ekps_pkg::OP_INSERT && !q.has_pos) begin
      r.status = ekps_pkg::ST_NO_POSITION;
      return r;
    end
    // Every scan frees expired entries first.
    freed = 0;
    for (int i = 0; i < ekps_pkg::ENTRIES; i++) begin
      if (slots[i].valid &&
          64'(slots[i].time_s) + 64'(store_time_s) < 64'(q.now_s)) begin
        slots[i].valid = 1'b0;
        freed++;
      end
    end
    r.purged = (freed > 511) ? 9'd511 : 9'(freed);
    case (q.op)
      ekps_pkg::OP_INSERT: begin
        hit = 1'b0;
        for (int i = 0; i < ekps_pkg::ENTRIES; i++) begin
          if (slots[i].valid && slots[i].key_len == len &&
              slots[i].key_head == head && slots[i].key_last == last) begin
            slots[i].time_s = q.arrival_s;
            slots[i].lat    = q.lat;
            slots[i].lon    = q.lon;
            slots[i].coslat = q.coslat;
            slots[i].kind   = q.kind;
            slots[i].flags  = q.flags;
            hit = 1'b1;
          end
        end
        if (hit) begin
          r.status = ekps_pkg::ST_UPDATED;
        end else begin
          r.status = ekps_pkg::ST_FULL;
          for (int i = 0; i < ekps_pkg::ENTRIES; i++) begin
            if (!slots[i].valid) begin
              slots[i] = '{valid: 1'b1, key_head: head, key_last: last,
                           key_len: len, time_s: q.arrival_s, lat: q.lat,
                           lon: q.lon, coslat: q.coslat, kind: q.kind,
                           flags: q.flags};
              r.status = ekps_pkg::ST_ADDED;
              break;
            end
          end
        end
      end
      ekps_pkg::OP_KILL: begin
        r.status = ekps_pkg::ST_KILL_ABSENT;
        for (int i = 0; i < ekps_pkg::ENTRIES; i++) begin
          if (slots[i].valid && slots[i].key_len == len &&
              slots[i].key_head == head && slots[i].key_last == last) begin
            slots[i].valid = 1'b0;
            r.status = ekps_pkg::ST_REMOVED;
          end
        end
      end
      ekps_pkg::OP_LOOKUP: begin
        r.status = ekps_pkg::ST_NOT_FOUND;
        for (int i = 0; i < ekps_pkg::ENTRIES; i++) begin
          if (slots[i].valid && slots[i].key_len == len &&
              slots[i].key_head == head && slots[i].key_last == last &&
              64'(slots[i].time_s) + 64'(store_time_s) >
              64'(q.now_s) + 64'(margin_s)) begin
            r.status = ekps_pkg::ST_FOUND;
            r.lat    = slots[i].lat;
            r.lon    = slots[i].lon;
            r.coslat = slots[i].coslat;
            r.time_s = slots[i].time_s;
            r.kind   = slots[i].kind;
            r.flags  = slots[i].flags;
            break;
          end
        end
      end
      default: r.status = ekps_pkg::ST_ADDED;
    endcase
    return r;
  endfunction

  task automatic report(input string field, input logic [63:0] got,
                        input logic [63:0] want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    errors++;
  endtask

  // Sends one transaction; the expectation is formed when it is accepted.
  task automatic send_query(input query_t q);
    int gap;
    operation_i         <= q.op;
    key_low_i           <= q.key_low;
    key_tail_i          <= q.key_tail;
    key_length_i        <= q.key_length;
    current_time_i      <= q.now_s;
    arrival_time_i      <= q.arrival_s;
    has_position_i      <= q.has_pos;
    latitude_bits_i     <= q.lat;
    longitude_bits_i    <= q.lon;
    cos_latitude_bits_i <= q.coslat;
    packet_kind_i       <= q.kind;
    packet_flags_i      <= q.flags;
    in_valid_i          <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_replies.push_back(predict_store(q));
    // Random idle between transactions.
    if (!quiet && $urandom_range(0, 99) < 19) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input ekps_pkg::reg_e idx, input logic [19:0] value);
    drain_replies();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ekps_pkg::REG_STORE_TIME) store_time_s = value;
    else margin_s = value[11:0];
  endtask

  function automatic query_t make_query(input ekps_pkg::op_e op, input int slot,
                                        input logic [31:0] now_s,
                                        input logic [31:0] arrival_s);
    query_t q;
    q.op         = op;
    q.key_low    = pool_key[slot];
    q.key_tail   = pool_tail[slot];
    q.key_length = pool_len[slot];
    q.now_s      = now_s;
    q.arrival_s  = arrival_s;
    q.has_pos    = 1'b1;
    q.lat        = $urandom();
    q.lon        = $urandom();
    q.coslat     = $urandom();
    q.kind       = 16'($urandom());
    q.flags      = $urandom();
    return q;
  endfunction

  // Corner cases under the reset configuration.
  task automatic test_corner_cases();
    query_t q;
    q = make_query(ekps_pkg::OP_INSERT, 0, 32'd5000, 32'd4000);
    q.has_pos = 1'b0;
    send_query(q);
    send_query(make_query(ekps_pkg::OP_INSERT, 0, 32'd5000, 32'd4000));
    send_query(make_query(ekps_pkg::OP_INSERT, 0, 32'd5000, 32'd4900));
    send_query(make_query(ekps_pkg::OP_LOOKUP, 0, 32'd5000, 32'd0));
    // Found until the margin before expiry, then not found but still stored.
    send_query(make_query(ekps_pkg::OP_LOOKUP, 0, 32'd8199, 32'd0));
    send_query(make_query(ekps_pkg::OP_LOOKUP, 0, 32'd8200, 32'd0));
    send_query(make_query(ekps_pkg::OP_CLEANUP, 0, 32'd8500, 32'd0));
    send_query(make_query(ekps_pkg::OP_CLEANUP, 0, 32'd8501, 32'd0));
    q = make_query(ekps_pkg::OP_KILL, 0, 32'd8501, 32'd0);
    q.has_pos = 1'b0;
    send_query(q);
    // Length zero key, and an over-long length with noise past the key.
    q = make_query(ekps_pkg::OP_INSERT, 1, 32'd100, 32'd90);
    q.key_length = 4'd0;
    q.key_low    = '1;
    send_query(q);
    q.op = ekps_pkg::OP_LOOKUP;
    q.key_low = 64'h1234;
    send_query(q);
    q = make_query(ekps_pkg::OP_INSERT, 2, 32'd100, 32'd100);
    q.key_length = 4'd15;
    send_query(q);
    q.key_length = 4'd9;
    q.op = ekps_pkg::OP_LOOKUP;
    send_query(q);
    q.key_length = 4'd8;
    send_query(q);
    q = make_query(ekps_pkg::OP_INSERT, 3, 32'd100, 32'd100);
    q.key_length = 4'd3;
    q.key_low = 64'h00AA_BBCC_DD11_2233;
    q.key_tail = 8'hFF;
    send_query(q);
    q.op = ekps_pkg::OP_KILL;
    q.key_low = 64'hFFFF_FFFF_FF11_2233;
    q.key_tail = 8'h00;
    send_query(q);
    send_query(q);
    // All-ones fields and times at the top of the range.
    q = '{op: ekps_pkg::OP_INSERT, key_low: '1, key_tail: '1, key_length: 4'd9,
          now_s: '1, arrival_s: '1, has_pos: 1'b1, lat: '1, lon: '1, coslat: '1,
          kind: '1, flags: '1};
    send_query(q);
    q.op = ekps_pkg::OP_LOOKUP;
    send_query(q);
    q.op = ekps_pkg::OP_CLEANUP;
    send_query(q);
    q.op = ekps_pkg::OP_KILL;
    send_query(q);
  endtask

  // Fills every slot, overflows once, then purges the whole store.
  task automatic test_full_store();
    query_t q;
    reply_t r;
    int     n;
    quiet = 1'b1;
    n = 0;
    do begin
      q = make_query(ekps_pkg::OP_INSERT, 0, 32'd20000, 32'd20000);
      q.key_length = 4'd9;
      q.key_low    = {32'hF00D_0000, 32'(n)};
      q.key_tail   = 8'h5A;
      send_query(q);
      r = pending_replies[$];
      n++;
    end while (r.status != ekps_pkg::ST_FULL && n < 300);
    q.op = ekps_pkg::OP_LOOKUP;
    send_query(q);
    q.key_low = {32'hF00D_0000, 32'd7};
    q.op = ekps_pkg::OP_INSERT;
    send_query(q);
    quiet = 1'b0;
    drain_replies();
    send_query(make_query(ekps_pkg::OP_CLEANUP, 0, '1, 32'd0));
  endtask

  // One random phase with the current configuration.
  task automatic test_random_phase(input int items);
    query_t      q;
    int          pick;
    int          slot;
    logic [31:0] span;
    logic [63:0] keep;
    for (int k = 0; k < items; k++) begin
      // A calm stretch with no idling at all in the middle of each phase.
      quiet = (k >= items / 3 && k < items / 3 + 60);
      span = 32'(store_time_s) + 32'(margin_s) + 32'd20;
      pick = $urandom_range(0, 99);
      if (pick < 3) clock_s = $urandom();
      else clock_s = clock_s + $urandom_range(0, store_time_s / 16 + 2);
      slot = $urandom_range(0, POOL - 1);
      q = make_query(ekps_pkg::OP_INSERT, slot, clock_s,
                     clock_s - $urandom_range(0, span));
      pick = $urandom_range(0, 99);
      if (pick < 45) q.op = ekps_pkg::OP_INSERT;
      else if (pick < 60) q.op = ekps_pkg::OP_KILL;
      else if (pick < 90) q.op = ekps_pkg::OP_LOOKUP;
      else q.op = ekps_pkg::OP_CLEANUP;
      q.has_pos = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 19) == 0) q.arrival_s = $urandom();
      // Noise in the characters past the key length.
      keep = (q.key_length >= 4'd8) ? '1 :
             ((64'd1 << (8 * q.key_length)) - 64'd1);
      if ($urandom_range(0, 1) == 1) begin
        q.key_low = q.key_low | ({$urandom(), $urandom()} & ~keep);
        if (q.key_length < 4'd9) q.key_tail = 8'($urandom());
      end
      send_query(q);
    end
  endtask

  // Result checker and receiver stall.
  always @(posedge clk_i) begin
    reply_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_replies.size() == 0) begin
        report("unexpected result, status", status_o, 0);
      end else begin
        w = pending_replies.pop_front();
        replies_seen++;
        status_seen[status_o]++;
        purged_total += purged_count_o;
        if (status_o != w.status) report("status", status_o, w.status);
        if (found_latitude_o != w.lat) report("found_latitude", found_latitude_o, w.lat);
        if (found_longitude_o != w.lon) report("found_longitude", found_longitude_o, w.lon);
        if (found_cos_latitude_o != w.coslat)
          report("found_cos_latitude", found_cos_latitude_o, w.coslat);
        if (found_time_o != w.time_s) report("found_time", found_time_o, w.time_s);
        if (found_kind_o != w.kind) report("found_kind", found_kind_o, w.kind);
        if (found_flags_o != w.flags) report("found_flags", found_flags_o, w.flags);
        if (purged_count_o != w.purged) report("purged_count", purged_count_o, w.purged);
      end
    end
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 19);
  end

  initial begin
    errors = 0;
    replies_seen = 0;
    purged_total = 0;
    quiet = 1'b0;
    clock_s = 32'd100000;
    store_time_s = ekps_pkg::STORE_TIME_RST;
    margin_s = ekps_pkg::MARGIN_RST;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (slots[i]) slots[i] = '0;
    for (int i = 0; i < POOL; i++) begin
      pool_key[i]  = {$urandom(), $urandom()};
      pool_tail[i] = 8'($urandom());
      pool_len[i]  = 4'($urandom_range(0, 15));
    end
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_index_i         <= ekps_pkg::REG_STORE_TIME;
    cfg_data_i          <= '0;
    in_valid_i          <= 1'b0;
    out_stall_i         <= 1'b0;
    operation_i         <= ekps_pkg::OP_INSERT;
    key_low_i           <= '0;
    key_tail_i          <= '0;
    key_length_i        <= '0;
    current_time_i      <= '0;
    arrival_time_i      <= '0;
    has_position_i      <= 1'b0;
    latitude_bits_i     <= '0;
    longitude_bits_i    <= '0;
    cos_latitude_bits_i <= '0;
    packet_kind_i       <= '0;
    packet_flags_i      <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_cases();
    test_full_store();
    test_random_phase(240);
    write_config(ekps_pkg::REG_STORE_TIME, 20'd0);
    write_config(ekps_pkg::REG_MARGIN, 20'd0);
    test_random_phase(240);
    write_config(ekps_pkg::REG_STORE_TIME, 20'd604800);
    write_config(ekps_pkg::REG_MARGIN, 20'd3600);
    test_random_phase(240);
    write_config(ekps_pkg::REG_STORE_TIME, 20'd40);
    write_config(ekps_pkg::REG_MARGIN, 20'd15);
    test_random_phase(250);

    drain_replies();
    repeat (20) @(posedge clk_i);
    if (pending_replies.size() != 0)
      report("results never arrived", pending_replies.size(), 0);
    $display("Checked %0d results (added %0d, updated %0d, found %0d, full %0d),",
             replies_seen, status_seen[ekps_pkg::ST_ADDED],
             status_seen[ekps_pkg::ST_UPDATED], status_seen[ekps_pkg::ST_FOUND],
             status_seen[ekps_pkg::ST_FULL]);
    $display("%0d expired entries purged, across four store time settings.",
             purged_total);
    if (errors == 0) begin
      $display("expiring_keyed_position_store: match");
    end else begin
      $display("expiring_keyed_position_store: mismatch");
    end
    $finish;
  end

endmodule
